### rtl/core/tsbw_pkg.sv
package tsbw_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned SLOP_AND_BASE = 3;

    typedef enum logic [1:0] {
        WRAP_BORDER = 2'd0,
        WRAP_TILE   = 2'd1,
        WRAP_CLAMP  = 2'd2,
        WRAP_SPARE  = 2'd3
    } wrap_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_WRAP   = 3'd0,
        REG_V_WRAP   = 3'd1,
        REG_U_SCALE  = 3'd2,
        REG_V_SCALE  = 3'd3,
        REG_BORDER   = 3'd4,
        REG_WIDTH    = 3'd5,
        REG_HEIGHT   = 3'd6,
        REG_UNUSED   = 3'd7
    } cfg_reg_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // floor(t * scale / 256), saturated to signed 32 bits; p is the 49-bit product
    function automatic logic signed [COORD_W:0] sat_scaled(input logic signed [48:0] p);
        logic signed [40:0] q;
        begin
            q = 41'(p >>> 8);
            if (q > 41'sh0_7FFF_FFFF) begin
                sat_scaled = 33'sh0_7FFF_FFFF;
            end else if (q < -41'sh0_8000_0000) begin
                sat_scaled = -33'sh0_8000_0000;
            end else begin
                sat_scaled = q[COORD_W:0];
            end
        end
    endfunction

endpackage

### rtl/core/tsbw_ram.sv
module tsbw_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/tsbw_coord.sv
// Per-axis coordinate path: scale (stage A), wrap + index multiply (stage B).
// Fully pipelined, two register stages, advanced by en.
module tsbw_coord
    import tsbw_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 256
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [COORD_W-1:0]       tex,
    input  logic [15:0]                     scale,
    input  logic [1:0]                      mode,
    input  logic [SIZE_W-1:0]               size_in_use,
    output logic                            out_border,
    output logic [$clog2(MAX_SIZE)-1:0]     idx,
    output logic                            idx_ovf,
    output logic [FRAC_W-1:0]               frac
);

    localparam int unsigned IDX_W = $clog2(MAX_SIZE);
    localparam int unsigned MS_W  = $clog2(MAX_SIZE + 1);
    localparam int unsigned PROD_W = FRAC_W + 1 + MS_W;

    logic signed [COORD_W:0] scaled_reg;
    logic [1:0]              mode_reg;
    logic [MS_W-1:0]         span_reg;
    logic                    border_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic [MS_W-1:0]  size_lim;
    logic [FRAC_W:0]  c_wrapped;
    logic             c_border;
    logic signed [48:0] raw_prod;

    always_comb begin
        if (size_in_use < SIZE_W'(4)) begin
            size_lim = MS_W'(4);
        end else if (32'(size_in_use) > MAX_SIZE) begin
            size_lim = MS_W'(MAX_SIZE);
        end else begin
            size_lim = MS_W'(size_in_use);
        end
        raw_prod = 49'(tex) * $signed({33'd0, scale});
    end

    always_comb begin
        c_border  = 1'b0;
        c_wrapped = '0;
        unique case (wrap_mode_t'(mode_reg))
            WRAP_BORDER: begin
                if (scaled_reg < 0 || scaled_reg > 33'sd65536) begin
                    c_border = 1'b1;
                end
                c_wrapped = scaled_reg[FRAC_W:0];
            end
            WRAP_TILE: begin
                c_wrapped = {1'b0, scaled_reg[FRAC_W-1:0]};
            end
            WRAP_CLAMP, WRAP_SPARE: begin
                if (scaled_reg < 0) begin
                    c_wrapped = '0;
                end else if (scaled_reg > 33'sd65536) begin
                    c_wrapped = 17'h10000;
                end else begin
                    c_wrapped = scaled_reg[FRAC_W:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scaled_reg <= sat_scaled(raw_prod);
            mode_reg   <= mode;
            span_reg   <= size_lim - MS_W'(SLOP_AND_BASE);
            border_reg <= c_border;
            prod_reg   <= PROD_W'(c_wrapped) * PROD_W'(span_reg);
        end
    end

    assign out_border = border_reg;
    assign frac       = prod_reg[FRAC_W-1:0];
    assign idx        = prod_reg[FRAC_W +: IDX_W];
    // unless the border flag is set, index = span at most, which is below MAX_SIZE, so the top bits stay clear
    assign idx_ovf    = |(prod_reg >> (FRAC_W + IDX_W));

endmodule

### rtl/core/tsbw_blend.sv
// Bilinear blend: weights (stage 1), per-tap products (stage 2), sum and round (stage 3).
module tsbw_blend
    import tsbw_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [FRAC_W-1:0]  tu,
    input  logic [FRAC_W-1:0]  tv,
    input  logic [RGB_W-1:0]   tx0,
    input  logic [RGB_W-1:0]   tx1,
    input  logic [RGB_W-1:0]   tx2,
    input  logic [RGB_W-1:0]   tx3,
    output logic [RGB_W-1:0]   rgb
);

    logic [32:0]      wt_reg  [4];
    logic [RGB_W-1:0] tx_reg  [4];
    logic [40:0]      prod_reg [4][3];
    logic [RGB_W-1:0] rgb_reg;

    logic [FRAC_W:0] cu, cv;
    logic [RGB_W-1:0] tx_in [4];
    logic [42:0] acc [3];

    assign cu = 17'h10000 - {1'b0, tu};
    assign cv = 17'h10000 - {1'b0, tv};
    assign tx_in[0] = tx0;
    assign tx_in[1] = tx1;
    assign tx_in[2] = tx2;
    assign tx_in[3] = tx3;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = 43'h0_8000_0000 + 43'(prod_reg[0][c]) + 43'(prod_reg[1][c])
                   + 43'(prod_reg[2][c]) + 43'(prod_reg[3][c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wt_reg[0] <= 33'(cu * cv);
            wt_reg[1] <= 33'({1'b0, tu} * cv);
            wt_reg[2] <= 33'(cu * {1'b0, tv});
            wt_reg[3] <= 33'({1'b0, tu} * {1'b0, tv});
            for (int k = 0; k < 4; k++) begin
                tx_reg[k] <= tx_in[k];
                for (int c = 0; c < 3; c++) begin
                    prod_reg[k][c] <= 41'(tx_reg[k][8*c +: 8]) * 41'(wt_reg[k]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                rgb_reg[8*c +: 8] <= acc[c][39:32];
            end
        end
    end

    assign rgb = rgb_reg;

endmodule

### rtl/core/texture_sampler_bilinear_wrap_core.sv
// Bilinear texture sampler with per-axis border/tile/clamp addressing.
// Input stream (s_axis_*): opcode in tuser; write transactions store one texel,
// sample transactions carry Q16.16 (u, v). Result stream (m_axis_*): one
// transaction per sample, none per write; tuser carries used_border.
// Configuration: cfg_we/cfg_index/cfg_data, write only, while the block is idle.
// Throughput: one transaction per cycle unless m_axis_tready holds the pipeline.
// From accept to a valid result there are eight register stages (2 coordinate,
// address, memory read, 3 blend, output), the first loaded at accept.
// The texel store is four banks split by row/column parity, so the four
// neighbours are read in the same cycle.
// A texel write follows the samples down to the memory-read stage and lands in
// the store there, so reads and writes keep their order.
// When m_axis_tready is low the whole pipeline holds and s_axis_tready drops
// unless the output register is empty; nothing is lost or repeated.
// Reset clears valid bits and sets the configuration registers to their reset values; texel contents
// are undefined until written.
module texture_sampler_bilinear_wrap_core
    import tsbw_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tex_u[31:0], tex_v[63:32], texel_col[71:64], texel_row[79:72], texel_rgb[103:80]
    input  logic [103:0]           s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [23:0]            m_axis_tdata,
    // used_border
    output logic                   m_axis_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned BA_W = CW + RW - 2;
    localparam int unsigned BANK_DEPTH = 1 << BA_W;
    localparam int unsigned NST = 7;

    // configuration
    logic [1:0]        u_mode_reg, v_mode_reg;
    logic [15:0]       u_scale_reg, v_scale_reg;
    logic [RGB_W-1:0]  border_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_mode_reg  <= WRAP_TILE;
            v_mode_reg  <= WRAP_TILE;
            u_scale_reg <= 16'd256;
            v_scale_reg <= 16'd256;
            border_reg  <= '0;
            width_reg   <= SIZE_W'(256);
            height_reg  <= SIZE_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_U_WRAP:  u_mode_reg  <= cfg_data[1:0];
                REG_V_WRAP:  v_mode_reg  <= cfg_data[1:0];
                REG_U_SCALE: u_scale_reg <= cfg_data[15:0];
                REG_V_SCALE: v_scale_reg <= cfg_data[15:0];
                REG_BORDER:  border_reg  <= cfg_data;
                REG_WIDTH:   width_reg   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_data[SIZE_W-1:0];
                REG_UNUSED:  ;
            endcase
        end
    end

    // pipeline control: stage k valid, sample-only (writes leave at entry)
    logic          en;
    logic [NST-1:0] vld_reg;
    logic          out_vld_reg;
    logic          s_acc, is_sample;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_sample     = s_acc && (s_axis_tuser == OP_SAMPLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NST-2:0], is_sample};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    // texel write, carried through stages 0..2 and stored at the read stage
    logic [2:0]       wr_reg;
    logic [CW-1:0]    wcol_reg [3];
    logic [RW-1:0]    wrow_reg [3];
    logic [RGB_W-1:0] wrgb_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
        end else if (en) begin
            wr_reg <= {wr_reg[1:0], s_acc && (s_axis_tuser == OP_WRITE)
                       && (32'(s_axis_tdata[71:64]) < MAX_WIDTH)
                       && (32'(s_axis_tdata[79:72]) < MAX_HEIGHT)};
        end
        if (en) begin
            wcol_reg[0] <= CW'(s_axis_tdata[71:64]);
            wrow_reg[0] <= RW'(s_axis_tdata[79:72]);
            wrgb_reg[0] <= s_axis_tdata[103:80];
            for (int k = 1; k < 3; k++) begin
                wcol_reg[k] <= wcol_reg[k-1];
                wrow_reg[k] <= wrow_reg[k-1];
                wrgb_reg[k] <= wrgb_reg[k-1];
            end
        end
    end

    // coordinate units (stage 0,1)
    logic          bu, bv, ou, ov;
    logic [CW-1:0] iu;
    logic [RW-1:0] iv;
    logic [FRAC_W-1:0] fu, fv;

    tsbw_coord #(.MAX_SIZE(MAX_WIDTH)) u_cu (
        .aclk(aclk), .en(en), .tex(s_axis_tdata[31:0]), .scale(u_scale_reg),
        .mode(u_mode_reg), .size_in_use(width_reg),
        .out_border(bu), .idx(iu), .idx_ovf(ou), .frac(fu)
    );
    tsbw_coord #(.MAX_SIZE(MAX_HEIGHT)) u_cv (
        .aclk(aclk), .en(en), .tex(s_axis_tdata[63:32]), .scale(v_scale_reg),
        .mode(v_mode_reg), .size_in_use(height_reg),
        .out_border(bv), .idx(iv), .idx_ovf(ov), .frac(fv)
    );

    // stage 2: neighbour addresses and bank mapping
    logic [CW:0] col0_reg, col1_reg;
    logic [RW:0] row0_reg, row1_reg;
    logic [FRAC_W-1:0] fu2_reg, fv2_reg, fu3_reg, fv3_reg;
    logic [NST-1:2] brd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            col0_reg <= {ou, iu};
            col1_reg <= {ou, iu} + (CW+1)'(1);
            row0_reg <= {ov, iv};
            row1_reg <= {ov, iv} + (RW+1)'(1);
            fu2_reg  <= fu;
            fv2_reg  <= fv;
            fu3_reg  <= fu2_reg;
            fv3_reg  <= fv2_reg;
            brd_reg[2] <= bu || bv;
            for (int k = 3; k < NST; k++) begin
                brd_reg[k] <= brd_reg[k-1];
            end
        end
    end

    // four banks: bank = {row[0], col[0]}, address = {row>>1, col>>1}
    logic [RGB_W-1:0] bank_q [4];
    logic [1:0]       sel_reg;
    logic             oob_next [4];
    logic             oob_reg [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BC = 1'(b % 2);
        localparam logic BR = 1'(b / 2);
        logic [CW:0] rc;
        logic [RW:0] rr;
        logic [BA_W-1:0] ra, wa;
        logic we_b;
        // each bank takes the neighbour whose column and row parity match its own
        assign rc = ((col0_reg[0] == BC) ? col0_reg : col1_reg);
        assign rr = ((row0_reg[0] == BR) ? row0_reg : row1_reg);
        assign ra = BA_W'({rr[RW-1:1], rc[CW-1:1]});
        assign wa = BA_W'({wrow_reg[2][RW-1:1], wcol_reg[2][CW-1:1]});
        assign we_b = en && wr_reg[2] && (wcol_reg[2][0] == BC) && (wrow_reg[2][0] == BR);
        assign oob_next[b] = (32'(rc) >= MAX_WIDTH) || (32'(rr) >= MAX_HEIGHT);
        tsbw_ram #(.WIDTH(RGB_W), .DEPTH(BANK_DEPTH)) u_ram (
            .aclk(aclk), .we(we_b), .waddr(wa), .wdata(wrgb_reg[2]),
            .re(en), .raddr(ra), .rdata(bank_q[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg <= {row0_reg[0], col0_reg[0]};
            for (int k = 0; k < 4; k++) begin
                oob_reg[k] <= oob_next[k];
            end
        end
    end

    // tap k: 0 (c0,r0), 1 (c1,r0), 2 (c0,r1), 3 (c1,r1)
    logic [RGB_W-1:0] tap [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [1:0] bsel;
            bsel = 2'(k) ^ sel_reg;
            tap[k] = oob_reg[bsel] ? '0 : bank_q[bsel];
        end
    end

    logic [RGB_W-1:0] blend_rgb;
    tsbw_blend u_blend (
        .aclk(aclk), .en(en), .tu(fu3_reg), .tv(fv3_reg),
        .tx0(tap[0]), .tx1(tap[1]), .tx2(tap[2]), .tx3(tap[3]), .rgb(blend_rgb)
    );

    // output register
    logic [23:0] out_data_reg;
    logic        out_brd_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_brd_reg  <= brd_reg[NST-1];
            out_data_reg <= brd_reg[NST-1]
                ? {border_reg[7:0], border_reg[15:8], border_reg[23:16]}
                : {blend_rgb[7:0], blend_rgb[15:8], blend_rgb[23:16]};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_brd_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[NST-1]) |=> m_axis_tvalid)
        else $error("sample lost at output");
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_axis_tuser == OP_WRITE) |=> !vld_reg[0])
        else $error("write produced a result");

endmodule

### sim/texture_sampler_bilinear_wrap_core_tb.sv
`timescale 1ns / 1ps

module texture_sampler_bilinear_wrap_core_tb
    import tsbw_pkg::*;
();

    localparam int unsigned TEX_W = 256;
    localparam int unsigned TEX_H = 256;
    localparam int unsigned LATENCY = 8;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned ITEMS_PER_SETTING = 90;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       border;
    } colour_t;

    class colour_checker;
        logic [23:0]   store [0:TEX_W*TEX_H-1];
        bit            loaded [0:TEX_W*TEX_H-1];
        colour_t       expected_colours [$];
        wrap_mode_t    u_mode, v_mode;
        logic [15:0]   u_scale, v_scale;
        logic [23:0]   border_rgb;
        logic [8:0]    width_reg, height_reg;
        int            errors;
        int            n_samples, n_borders, n_writes;

        function new();
            u_mode = WRAP_TILE;
            v_mode = WRAP_TILE;
            u_scale = 16'd256;
            v_scale = 16'd256;
            border_rgb = '0;
            width_reg = 9'd256;
            height_reg = 9'd256;
            errors = 0;
            n_samples = 0;
            n_borders = 0;
            n_writes = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [23:0] val);
            case (idx)
                REG_U_WRAP:  u_mode = wrap_mode_t'(val[1:0]);
                REG_V_WRAP:  v_mode = wrap_mode_t'(val[1:0]);
                REG_U_SCALE: u_scale = val[15:0];
                REG_V_SCALE: v_scale = val[15:0];
                REG_BORDER:  border_rgb = val;
                REG_WIDTH:   width_reg = val[8:0];
                REG_HEIGHT:  height_reg = val[8:0];
                default: ;
            endcase
        endfunction

        // floor(t * scale / 256) with saturation to signed 32 bits
        function longint scaled(logic [31:0] t, logic [15:0] s);
            longint p, q;
            p = longint'($signed(t)) * longint'({48'd0, s});
            q = p >>> 8;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            return q;
        endfunction

        function bit wrap(longint c, wrap_mode_t m, output longint unsigned oc);
            longint cc;
            cc = c;
            oc = 0;
            case (m)
                WRAP_BORDER: begin
                    if (cc < 0 || cc > 65536) return 0;
                    oc = cc;
                end
                WRAP_TILE: oc = cc & 64'hFFFF;
                default: begin
                    if (cc < 0) cc = 0;
                    if (cc > 65536) cc = 65536;
                    oc = cc;
                end
            endcase
            return 1;
        endfunction

        function int unsigned size_limit(logic [8:0] s, int unsigned maxv);
            if (s < 4) return 4;
            if (s > maxv) return maxv;
            return s;
        endfunction

        // texel index and fraction on both axes; returns 0 when border colour applies
        function bit locate(logic [31:0] u, logic [31:0] v, output int unsigned iu,
                            output int unsigned iv, output longint unsigned fu,
                            output longint unsigned fv);
            longint unsigned cu, cv, su, sv;
            iu = 0; iv = 0; fu = 0; fv = 0;
            if (!wrap(scaled(u, u_scale), u_mode, cu)) return 0;
            if (!wrap(scaled(v, v_scale), v_mode, cv)) return 0;
            su = cu * (size_limit(width_reg, TEX_W) - SLOP_AND_BASE);
            sv = cv * (size_limit(height_reg, TEX_H) - SLOP_AND_BASE);
            iu = 32'(su >> 16);
            iv = 32'(sv >> 16);
            fu = su & 64'hFFFF;
            fv = sv & 64'hFFFF;
            return 1;
        endfunction

        function void note_input(logic op, logic [103:0] d);
            int unsigned iu, iv, k;
            longint unsigned fu, fv, acc;
            longint unsigned wt [4];
            logic [23:0] tx [4];
            colour_t c;
            if (op == OP_WRITE) begin
                store[d[79:72]*TEX_W + d[71:64]] = d[103:80];
                n_writes++;
                return;
            end
            n_samples++;
            if (!locate(d[31:0], d[63:32], iu, iv, fu, fv)) begin
                c = {border_rgb, 1'b1};
                n_borders++;
            end else begin
                tx[0] = store[iv*TEX_W + iu];
                tx[1] = store[iv*TEX_W + iu + 1];
                tx[2] = store[(iv+1)*TEX_W + iu];
                tx[3] = store[(iv+1)*TEX_W + iu + 1];
                wt[0] = (65536 - fu) * (65536 - fv);
                wt[1] = fu * (65536 - fv);
                wt[2] = (65536 - fu) * fv;
                wt[3] = fu * fv;
                c.border = 1'b0;
                for (int ch = 0; ch < 3; ch++) begin
                    acc = 64'h8000_0000;
                    for (k = 0; k < 4; k++)
                        acc += longint'(tx[k][23-8*ch -: 8]) * wt[k];
                    case (ch)
                        0: c.red = acc[39:32];
                        1: c.green = acc[39:32];
                        default: c.blue = acc[39:32];
                    endcase
                end
            end
            expected_colours.push_back(c);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check(logic [23:0] d, logic brd);
            colour_t e;
            if (expected_colours.size() == 0) begin
                report($sformatf("unexpected result %h border %b", d, brd));
                return;
            end
            e = expected_colours.pop_front();
            if (d[7:0] != e.red)
                report($sformatf("red %h, want %h", d[7:0], e.red));
            if (d[15:8] != e.green)
                report($sformatf("green %h, want %h", d[15:8], e.green));
            if (d[23:16] != e.blue)
                report($sformatf("blue %h, want %h", d[23:16], e.blue));
            if (brd != e.border)
                report($sformatf("used_border %b, want %b", brd, e.border));
        endtask

        function int pending();
            return expected_colours.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [103:0]          s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    colour_checker sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold_req = 0;
    int  stall_cycles = 0;
    int  n_sent = 0;

    texture_sampler_bilinear_wrap_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("texture_sampler_bilinear_wrap_core_tb failed");
                $finish;
            end
        end
    end

    // receiver: random backpressure, or one long hold-off when asked
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req && !held) begin
                held = 1;
                hold = 300;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send(logic op, logic [103:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic put_texel(logic [7:0] col, logic [7:0] row, logic [23:0] rgb);
        sb.loaded[row*TEX_W + col] = 1;
        send(OP_WRITE, {rgb, row, col, 64'($urandom()) ^ {$urandom(), $urandom()}});
    endtask

    // loads any neighbour not yet written, then issues the sample
    task automatic sample(logic [31:0] u, logic [31:0] v);
        int unsigned iu, iv, c, r;
        longint unsigned fu, fv;
        if (sb.locate(u, v, iu, iv, fu, fv)) begin
            for (int k = 0; k < 4; k++) begin
                c = iu + (k % 2);
                r = iv + (k / 2);
                if (!sb.loaded[r*TEX_W + c])
                    put_texel(8'(c), 8'(r), 24'($urandom()));
            end
        end
        send(OP_SAMPLE, {24'($urandom()), 16'($urandom()), v, u});
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(4))
            0: return 24'd0;
            1: return 24'd65535;
            2: return 24'd256;
            default: return 24'($urandom_range(64, 1024));
        endcase
    endfunction

    function automatic logic [23:0] pick_size();
        case ($urandom_range(9))
            0: return 24'd4;
            1: return 24'd256;
            2: return 24'($urandom_range(0, 3));
            3: return 24'($urandom_range(257, 511));
            default: return 24'($urandom_range(4, 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0003_0000)) - 32'h0001_0000;
            2: return 32'h0001_0000;
            default: return 32'($urandom_range(0, 32'h0001_0000));
        endcase
    endfunction

    task automatic random_setting();
        drain();
        write_reg(REG_U_WRAP, 24'($urandom_range(0, 3)));
        write_reg(REG_V_WRAP, 24'($urandom_range(0, 3)));
        write_reg(REG_U_SCALE, pick_scale());
        write_reg(REG_V_SCALE, pick_scale());
        write_reg(REG_BORDER, 24'($urandom()));
        write_reg(REG_WIDTH, pick_size());
        write_reg(REG_HEIGHT, pick_size());
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 24'($urandom()));
    endtask

    initial begin
        int guard;
        int budget;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = OP_SAMPLE;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_U_WRAP;
        cfg_data = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset defaults are tile mode, unit scale, full size
        put_texel(8'd0, 8'd0, 24'h000000);
        put_texel(8'd255, 8'd255, 24'hFFFFFF);
        put_texel(8'd254, 8'd254, 24'hFFFFFF);
        sample(32'h0000_0000, 32'h0000_0000);
        sample(32'h0000_8000, 32'h0000_8000);
        sample(32'h7FFF_FFFF, 32'h8000_0000);
        sample(32'hFFFF_FFFF, 32'h0000_FFFF);
        drain();
        write_reg(REG_U_WRAP, 24'(WRAP_BORDER));
        write_reg(REG_V_WRAP, 24'(WRAP_BORDER));
        write_reg(REG_BORDER, 24'hFFFFFF);
        sample(32'hFFFF_FFFF, 32'h0000_8000);  // u below range
        sample(32'h0001_0001, 32'h0000_8000);  // u above range
        sample(32'h0000_8000, 32'h0001_0001);  // u fine, v out
        sample(32'h0001_0000, 32'h0001_0000);  // exactly one: far corner
        sample(32'h0000_0000, 32'h0000_0000);
        drain();
        write_reg(REG_U_SCALE, 24'd65535);
        write_reg(REG_V_SCALE, 24'd0);
        write_reg(REG_U_WRAP, 24'(WRAP_CLAMP));
        write_reg(REG_V_WRAP, 24'(WRAP_SPARE));
        write_reg(REG_WIDTH, 24'd4);
        write_reg(REG_HEIGHT, 24'd511);
        sample(32'h7FFF_FFFF, 32'h1234_5678);  // saturates high
        sample(32'h8000_0000, 32'h8000_0000);  // saturates low
        sample(32'h0000_0100, 32'h0000_0000);
        drain();
        write_reg(REG_WIDTH, 24'd0);
        write_reg(REG_HEIGHT, 24'd4);
        write_reg(REG_U_SCALE, 24'd256);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        sample(32'h0000_C000, 32'h0001_0000);
        sample(32'h0000_4000, 32'hFFFF_0000);

        for (int regime = 0; regime < 3; regime++) begin
            tx_idle_pct = (regime == 0) ? 20 : (regime == 1) ? 58 : 0;
            rx_idle_pct = (regime == 0) ? 58 : (regime == 1) ? 20 : 0;
            for (int s = 0; s < 4; s++) begin
                random_setting();
                if (regime == 0 && s == 1)
                    rx_hold_req = 1;
                budget = n_sent + ITEMS_PER_SETTING;
                while (n_sent < budget) begin
                    if ($urandom_range(4) == 0)
                        put_texel(8'($urandom()), 8'($urandom()), 24'($urandom()));
                    else
                        sample(pick_coord(), pick_coord());
                    if ($urandom_range(80) == 0) begin
                        // wait for everything to come back before carrying on
                        @(negedge aclk);
                        s_axis_tvalid <= 1'b0;
                        while (sb.pending() != 0) @(posedge aclk);
                    end
                end
            end
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        rx_idle_pct = 0;
        guard = 0;
        while (sb.pending() != 0 && guard < STALL_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY * 4) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d samples (%0d border) and %0d texel writes",
                 sb.n_samples, sb.n_borders, sb.n_writes);
        $display("across all wrap modes, scale and size extremes, with and without stalls");
        if (sb.errors == 0) begin
            $display("texture_sampler_bilinear_wrap_core_tb passed");
        end else begin
            $display("texture_sampler_bilinear_wrap_core_tb failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tsbw_pkg.sv
rtl/core/tsbw_ram.sv
rtl/core/tsbw_coord.sv
rtl/core/tsbw_blend.sv
rtl/core/texture_sampler_bilinear_wrap_core.sv
sim/texture_sampler_bilinear_wrap_core_tb.sv
